// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by kalman_trajectory_smoother_unit
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define KTS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) expr) else $error(msg);

// checked on every edge, reset included
`define KTS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) expr) else $error(msg);

`endif

// ===== hw/rtl/kts_pkg.sv =====
// shared constants for the kalman trajectory smoother
// no dependencies
package kts_pkg;

    localparam int DataWidth     = 32;
    localparam int PathWidth     = 48;
    localparam int VarWidth      = 32;
    localparam int GainWidth     = 31;
    localparam int MulWidth      = 32;
    localparam int DivSteps      = 31;
    localparam int CfgIndexWidth = 8;
    localparam int NumAxes       = 3;

    localparam logic [GainWidth-1:0] OneQ30 = GainWidth'(1 << 30);

    // q = 0.004 and r = 0.25 in unsigned q2.30
    localparam logic [VarWidth-1:0] ProcNoiseReset = 32'd4294967;
    localparam logic [VarWidth-1:0] MeasNoiseReset = 32'd268435456;

    localparam logic [CfgIndexWidth-1:0] CFG_PROCESS_NOISE = 8'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_MEASURE_NOISE = 8'd1;

endpackage

// ===== hw/rtl/kalman_trajectory_smoother_unit.sv =====
// kalman trajectory smoother: per-frame motion in, stabilized motion out
// an accepted motion word runs the serial gain divide, the per-axis estimate updates and the
// variance update before its result; the first motion word after reset and a panning word skip
// them; one word in process at a time, with a 31-step serial gain divider and a shared multiplier (7 passes)
// reset (aresetn low, synchronous): trajectory and estimates zero, variance 1.0,
// noise registers to 0.004 and 0.25, output empty
module kalman_trajectory_smoother_unit
    import kts_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [3*DataWidth-1:0]     s_tdata,   // shift_x, shift_y, turn_angle
    input  logic [0:0]                 s_tuser,   // motion_found
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [3*DataWidth-1:0]     m_tdata,   // fixed_x, fixed_y, fixed_angle
    output logic [0:0]                 m_tuser,   // panning
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CfgIndexWidth-1:0]   cfg_index,
    input  logic [DataWidth-1:0]       cfg_data
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIVS,
        ST_DIVW,
        ST_RES,
        ST_MHI,
        ST_MLO,
        ST_UPD,
        ST_VMUL,
        ST_VUPD,
        ST_OUT
    } state_t;

    localparam int ResWidth = PathWidth + 1;
    localparam int AccWidth = PathWidth + 2;
    localparam int FixWidth = PathWidth + 3;

    localparam logic signed [PathWidth-1:0] Max48 = {1'b0, {(PathWidth-1){1'b1}}};
    localparam logic signed [PathWidth-1:0] Min48 = {1'b1, {(PathWidth-1){1'b0}}};
    localparam logic [1:0] LastAxis = 2'(NumAxes - 1);

    state_t                       state_reg;
    logic [VarWidth-1:0]          q_reg;
    logic [VarWidth-1:0]          r_reg;
    logic signed [PathWidth-1:0]  path_reg [NumAxes];
    logic signed [PathWidth-1:0]  est_reg  [NumAxes];
    logic signed [DataWidth-1:0]  shift_reg [NumAxes];
    logic [VarWidth-1:0]          var_reg;
    logic                         past_first_reg;
    logic                         pan_reg;
    logic [VarWidth-1:0]          pp_reg;
    logic [GainWidth-1:0]         k_reg;
    logic [1:0]                   axis_reg;
    logic                         neg_reg;
    logic [ResWidth-1:0]          mag_reg;
    logic [AccWidth-1:0]          acc_reg;
    logic                         m_tvalid_reg;
    logic [3*DataWidth-1:0]       m_tdata_reg;
    logic                         m_tuser_reg;

    logic signed [PathWidth:0]    path_sum   [NumAxes];
    logic signed [PathWidth-1:0]  path_next  [NumAxes];
    logic signed [FixWidth-1:0]   fix_sum    [NumAxes];
    logic [3*DataWidth-1:0]       fix_word;
    logic [VarWidth:0]            pp_sum;
    logic [VarWidth-1:0]          pp_next;
    logic [VarWidth:0]            den;
    logic signed [ResWidth-1:0]   res;
    logic [ResWidth-1:0]          res_mag;
    logic [AccWidth-1:0]          step_mag;
    logic signed [AccWidth-1:0]   est_wide;
    logic signed [AccWidth-1:0]   est_next;
    logic [GainWidth-1:0]         k_next;
    logic [MulWidth-1:0]          mul_a;
    logic [MulWidth-1:0]          mul_b;
    logic [2*MulWidth-1:0]        mul_p;
    logic                         div_start;
    logic                         div_busy;
    logic                         div_done;
    logic [GainWidth-1:0]         div_q;
    logic                         out_free;

    function automatic logic [DataWidth-1:0] sat32(input logic signed [FixWidth-1:0] v);
        logic signed [FixWidth-1:0] hi_lim;
        logic signed [FixWidth-1:0] lo_lim;
        hi_lim = FixWidth'(signed'({1'b0, {(DataWidth-1){1'b1}}}));
        lo_lim = -hi_lim - FixWidth'(1);
        if (v > hi_lim) begin
            return {1'b0, {(DataWidth-1){1'b1}}};
        end else if (v < lo_lim) begin
            return {1'b1, {(DataWidth-1){1'b0}}};
        end
        return v[DataWidth-1:0];
    endfunction

    // per-axis lanes: trajectory accumulate and output correction
    always_comb begin
        for (int i = 0; i < NumAxes; i++) begin
            path_sum[i] = {path_reg[i][PathWidth-1], path_reg[i]}
                        + {{(PathWidth+1-DataWidth){shift_reg[i][DataWidth-1]}}, shift_reg[i]};
            if (path_sum[i][PathWidth] != path_sum[i][PathWidth-1]) begin
                path_next[i] = path_sum[i][PathWidth] ? Min48 : Max48;
            end else begin
                path_next[i] = path_sum[i][PathWidth-1:0];
            end
            fix_sum[i] = {{(FixWidth-DataWidth){shift_reg[i][DataWidth-1]}}, shift_reg[i]}
                       + {{(FixWidth-PathWidth){est_reg[i][PathWidth-1]}}, est_reg[i]}
                       - {{(FixWidth-PathWidth){path_reg[i][PathWidth-1]}}, path_reg[i]};
            fix_word[i*DataWidth +: DataWidth] = sat32(fix_sum[i]);
        end
    end

    assign pp_sum  = {1'b0, var_reg} + {1'b0, q_reg};
    assign pp_next = pp_sum[VarWidth] ? {VarWidth{1'b1}} : pp_sum[VarWidth-1:0];
    assign den     = {1'b0, pp_reg} + {1'b0, r_reg};

    // zero denominator gives zero gain; the clamp guards the q1.30 range
    always_comb begin
        if (den == '0) begin
            k_next = '0;
        end else if (div_q > OneQ30) begin
            k_next = OneQ30;
        end else begin
            k_next = div_q;
        end
    end

    assign res     = {path_reg[axis_reg][PathWidth-1], path_reg[axis_reg]}
                   - {est_reg[axis_reg][PathWidth-1], est_reg[axis_reg]};
    assign res_mag = res[ResWidth-1] ? ResWidth'(-res) : res;

    // hi part from the previous multiply plus the truncated lo part
    assign step_mag = acc_reg + {{(AccWidth-31){1'b0}}, mul_p[60:30]};
    assign est_wide = {{(AccWidth-PathWidth){est_reg[axis_reg][PathWidth-1]}},
                       est_reg[axis_reg]};
    assign est_next = neg_reg ? est_wide - signed'(step_mag) : est_wide + signed'(step_mag);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MHI: begin
                mul_a = {{(MulWidth-(ResWidth-30)){1'b0}}, mag_reg[ResWidth-1:30]};
                mul_b = {1'b0, k_reg};
            end
            ST_MLO: begin
                mul_a = {2'b00, mag_reg[29:0]};
                mul_b = {1'b0, k_reg};
            end
            ST_VMUL: begin
                mul_a = {1'b0, OneQ30 - k_reg};
                mul_b = pp_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_DIVS);
    assign out_free  = !m_tvalid_reg || m_tready;

    kts_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    kts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .pp       (pp_reg),
        .den      (den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            q_reg          <= ProcNoiseReset;
            r_reg          <= MeasNoiseReset;
            var_reg        <= VarWidth'(OneQ30);
            past_first_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            axis_reg       <= '0;
            for (int i = 0; i < NumAxes; i++) begin
                path_reg[i] <= '0;
                est_reg[i]  <= '0;
            end
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_PROCESS_NOISE) begin
                    q_reg <= cfg_data;
                end else if (cfg_index == CFG_MEASURE_NOISE) begin
                    r_reg <= cfg_data;
                end
            end
            // the output state reloads the word itself
            if (m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int i = 0; i < NumAxes; i++) begin
                            shift_reg[i] <= s_tdata[i*DataWidth +: DataWidth];
                        end
                        pan_reg   <= !s_tuser[0];
                        state_reg <= s_tuser[0] ? ST_ACCUM : ST_OUT;
                    end
                end
                ST_ACCUM: begin
                    for (int i = 0; i < NumAxes; i++) begin
                        path_reg[i] <= path_next[i];
                    end
                    pp_reg         <= pp_next;
                    past_first_reg <= 1'b1;
                    state_reg      <= past_first_reg ? ST_DIVS : ST_OUT;
                end
                ST_DIVS: begin
                    state_reg <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (div_done) begin
                        k_reg     <= k_next;
                        axis_reg  <= '0;
                        state_reg <= ST_RES;
                    end
                end
                ST_RES: begin
                    neg_reg   <= res[ResWidth-1];
                    mag_reg   <= res_mag;
                    state_reg <= ST_MHI;
                end
                ST_MHI: begin
                    state_reg <= ST_MLO;
                end
                ST_MLO: begin
                    acc_reg   <= mul_p[AccWidth-1:0];
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    est_reg[axis_reg] <= est_next[PathWidth-1:0];
                    if (axis_reg == LastAxis) begin
                        state_reg <= ST_VMUL;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_RES;
                    end
                end
                ST_VMUL: begin
                    state_reg <= ST_VUPD;
                end
                ST_VUPD: begin
                    var_reg   <= mul_p[61:30];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= pan_reg;
                        m_tdata_reg  <= pan_reg ? '0 : fix_word;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = 1'b1;

    `KTS_ASSERT(a_pan_keeps_first, (s_tvalid && s_tready && !s_tuser[0]) |=> $stable(past_first_reg), "panning word changed first-frame flag")
    `KTS_ASSERT(a_div_idle_start, div_start |-> !div_busy, "divider started while busy")
    `KTS_ASSERT(a_gain_range, (state_reg == ST_VUPD) |-> (k_reg <= OneQ30), "gain above one")
    `KTS_ASSERT_ALWAYS(a_reset_idle, (!aresetn) |=> (state_reg == ST_IDLE && !m_tvalid_reg), "not idle after reset")

endmodule

// ===== hw/rtl/kts_mul.sv =====
// shared unsigned multiplier with registered product
// depends on kts_pkg
module kts_mul
    import kts_pkg::*;
(
    input  logic                    aclk,
    input  logic [MulWidth-1:0]     op_a,
    input  logic [MulWidth-1:0]     op_b,
    output logic [2*MulWidth-1:0]   product
);

    logic [2*MulWidth-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

// ===== hw/rtl/kts_div.sv =====
// bit-serial restoring divider for the kalman gain: floor(pp * 2^30 / den)
// depends on kts_pkg
module kts_div
    import kts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VarWidth-1:0]   pp,
    input  logic [VarWidth:0]     den,
    output logic                  busy,
    output logic                  done,
    output logic [GainWidth-1:0]  quotient
);

    localparam int CntWidth = $clog2(DivSteps + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CntWidth-1:0]  cnt_reg;
    logic [VarWidth:0]    rem_reg;
    logic [VarWidth:0]    den_reg;
    logic                 bit_reg;
    logic [GainWidth-1:0] quot_reg;

    logic [VarWidth+1:0]  trial;
    logic [VarWidth+1:0]  diff;
    logic                 fits;

    // quotient is below 2^31, so the top bits of pp * 2^30 preload the remainder
    assign trial = {rem_reg, bit_reg};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntWidth'(DivSteps);
                rem_reg  <= {2'b00, pp[VarWidth-1:1]};
                bit_reg  <= pp[0];
                den_reg  <= den;
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[VarWidth:0] : trial[VarWidth:0];
                quot_reg <= {quot_reg[GainWidth-2:0], fits};
                bit_reg  <= 1'b0;
                cnt_reg  <= cnt_reg - CntWidth'(1);
                if (cnt_reg == CntWidth'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
